// ===== sv/gpa_pkg.sv =====
// Shared types, codes and constants for the GF(2) polynomial arithmetic unit.
package gpa_pkg;

	localparam int FIELD_W        = 32;
	localparam int POLY_WIDTH_DEF = 32;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_MUL = 2'd1;
	localparam logic [1:0] MODE_DIV = 2'd2;
	localparam logic [1:0] MODE_INV = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FIELD_W-1:0] operand_a;
		logic [FIELD_W-1:0] operand_b;
	} in_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] primary_result;
		logic [FIELD_W-1:0] secondary_result;
		logic               divide_by_zero;
		logic               no_inverse;
	} out_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SETUP,
		ST_NORM,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic norm_shift;
		logic div_step;
		logic update;
		logic capture;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       dsh_msb;
		logic       cnt_zero;
		logic       div_zero;
		logic       euclid_more;
	} dp_status_t;

endpackage

// ===== sv/gf2_poly_arith_unit.sv =====
// Top level of the GF(2) polynomial add, multiply, divide and inverse unit.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready   | in_req_t  (mode, operand_a, operand_b)
//   out     | output    | out_valid / out_ready | out_req_t (results and flags)
//
// One request at a time. A divide runs normalize shifts, then one quotient bit a
// cycle; a zero divisor skips both. An inverse runs up to W+2 Euclid passes,
// W = POLY_WIDTH. The single shift-and-xor engine serves multiply, divide, inverse.
// Reset clears the controller and the output valid; no clearing pass.
// A new request is taken while a finished result waits in the output register.
module gf2_poly_arith_unit
	import gpa_pkg::*;
#(
	parameter int POLY_WIDTH = POLY_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	gpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gpa_datapath #(
		.POLY_WIDTH (POLY_WIDTH)
	) u_datapath (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

// ===== sv/gpa_datapath.sv =====
// Datapath: shift-and-xor division/multiply engine with Euclid coefficient tracking.
module gpa_datapath
	import gpa_pkg::*;
#(
	parameter int POLY_WIDTH = POLY_WIDTH_DEF
) (
	input  logic       clk,
	input  in_req_t    in_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_req_t   out_data
);

	localparam int W     = POLY_WIDTH;
	localparam int CNT_W = $clog2(W);
	localparam int GRD_W = $clog2(W + 3);
	localparam logic [W-1:0] MSB_ONE = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE_W   = {{(W-1){1'b0}}, 1'b1};

	logic [1:0]       mode_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     div_q;
	logic [W-1:0]     dsh_q;
	logic [W-1:0]     top_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     tacc_q;
	logic [W-1:0]     t1_q;
	logic [W-1:0]     t2_q;
	logic [CNT_W-1:0] cnt_q;
	logic [GRD_W-1:0] guard_q;
	out_req_t         res_q;

	logic [W-1:0] a_w;
	logic [W-1:0] b_w;
	logic         hit;
	out_req_t     res_d;

	assign a_w = W'(in_data.operand_a);
	assign b_w = W'(in_data.operand_b);
	// Coefficient of the current leading position of the remainder
	assign hit = |(rem_q & top_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_data.mode;
			case (in_data.mode)
				MODE_ADD: begin
					tacc_q <= a_w ^ b_w;
				end
				MODE_MUL: begin
					// multiply runs on the divide step with a zero divisor
					rem_q  <= b_w;
					t2_q   <= a_w;
					tacc_q <= '0;
					top_q  <= MSB_ONE;
					dsh_q  <= '0;
					quo_q  <= '0;
					cnt_q  <= CNT_W'(W - 1);
				end
				MODE_DIV: begin
					rem_q <= a_w;
					div_q <= b_w;
				end
				default: begin
					rem_q   <= b_w;
					div_q   <= a_w;
					t1_q    <= '0;
					t2_q    <= ONE_W;
					guard_q <= '0;
				end
			endcase
		end
		if (cmd.setup) begin
			dsh_q  <= div_q;
			top_q  <= MSB_ONE;
			cnt_q  <= '0;
			quo_q  <= '0;
			tacc_q <= '0;
		end
		if (cmd.norm_shift) begin
			dsh_q <= dsh_q << 1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.div_step) begin
			quo_q  <= {quo_q[W-2:0], hit};
			rem_q  <= rem_q ^ (hit ? dsh_q : '0);
			tacc_q <= {tacc_q[W-2:0], 1'b0} ^ (hit ? t2_q : '0);
			dsh_q  <= dsh_q >> 1;
			top_q  <= top_q >> 1;
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.update) begin
			rem_q   <= div_q;
			div_q   <= rem_q;
			t1_q    <= t2_q;
			t2_q    <= t1_q ^ tacc_q;
			guard_q <= guard_q + 1'b1;
		end
		if (cmd.capture) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		res_d = '0;
		case (mode_q)
			MODE_ADD, MODE_MUL: begin
				res_d.primary_result = FIELD_W'(tacc_q);
			end
			MODE_DIV: begin
				res_d.primary_result   = FIELD_W'(quo_q);
				res_d.secondary_result = FIELD_W'(rem_q);
				res_d.divide_by_zero   = (div_q == '0);
			end
			default: begin
				res_d.primary_result   = FIELD_W'(t1_q);
				res_d.secondary_result = FIELD_W'(rem_q);
				res_d.no_inverse       = (rem_q != ONE_W);
			end
		endcase
	end

	assign status.mode        = mode_q;
	assign status.dsh_msb     = dsh_q[W-1];
	assign status.cnt_zero    = (cnt_q == '0);
	assign status.div_zero    = (div_q == '0);
	assign status.euclid_more = (div_q != '0) && (guard_q <= GRD_W'(W + 1));
	assign out_data           = res_q;

endmodule

// ===== sv/gpa_ctrl.sv =====
// Controller: sequences load, normalize, divide and Euclid update steps.
module gpa_ctrl
	import gpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	// result register may be refilled when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				case (status.mode)
					MODE_ADD: state_d = ST_DONE;
					MODE_MUL: state_d = ST_DIV;
					default:  state_d = ST_SETUP;
				endcase
			end
			ST_SETUP: begin
				if (status.mode == MODE_DIV) begin
					state_d = status.div_zero ? ST_DONE : ST_NORM;
				end else begin
					state_d = status.euclid_more ? ST_NORM : ST_DONE;
				end
			end
			ST_NORM: begin
				if (status.dsh_msb) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.cnt_zero) begin
					state_d = (status.mode == MODE_INV) ? ST_UPDATE : ST_DONE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_SETUP;
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_NORM: begin
				cmd.norm_shift = !status.dsh_msb;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_DONE: begin
				cmd.capture = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
